@@ hdl/mwd_pkg.sv @@
// ----------------------------------------------------------------------------
// Meter wheel digit decoder package
// Shared types, carry mode codes and small arithmetic helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mwd_pkg;

  // Widths of the item fields.
  localparam int ReadingW = 7;
  localparam int DigitW   = 4;
  localparam int ValueW   = 27;

  // Thresholds used by the carry rules.
  localparam logic [ReadingW-1:0] MidLow     = 7'd88;
  localparam logic [ReadingW-1:0] MidHigh    = 7'd94;
  localparam logic [ReadingW-1:0] CarryLimit = 7'd95;
  localparam logic [ReadingW-1:0] FloorLow   = 7'd90;
  localparam logic [ReadingW-1:0] StayHigh   = 7'd97;
  localparam logic [ReadingW-1:0] StayLow    = 7'd93;

  // Carry modes of the wheel below.
  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_CARRY  = 2'd1,
    MODE_FLOOR  = 2'd2
  } mode_t;

  // State about the lower wheel, handed to the decoder.
  typedef struct packed {
    mode_t                mode;
    logic [ReadingW-1:0]  lower_reading;
    logic                 lower_known;
  } lower_state_t;

  // Decoder result for one wheel.
  typedef struct packed {
    logic [DigitW-1:0] digit;
    logic              fail;
    mode_t             next_mode;
  } decode_t;

  // Quotient by ten for values below 160, by reciprocal multiplication.
  function automatic logic [3:0] div10(input logic [7:0] x);
    logic [15:0] p;
    p = {8'd0, x} * 16'd205;
    return p[14:11];
  endfunction

  // Remainder by ten for values below thirty.
  function automatic logic [DigitW-1:0] mod10(input logic [4:0] x);
    logic [4:0] y;
    if (x >= 5'd20) begin
      y = x - 5'd20;
    end else if (x >= 5'd10) begin
      y = x - 5'd10;
    end else begin
      y = x;
    end
    return y[DigitW-1:0];
  endfunction

  // Place weight of a wheel by its position in the reading.
  function automatic logic [ValueW-1:0] pow10(input logic [3:0] n);
    logic [ValueW-1:0] w;
    case (n)
      4'd0:    w = 27'd1;
      4'd1:    w = 27'd10;
      4'd2:    w = 27'd100;
      4'd3:    w = 27'd1000;
      4'd4:    w = 27'd10000;
      4'd5:    w = 27'd100000;
      4'd6:    w = 27'd1000000;
      4'd7:    w = 27'd10000000;
      4'd8:    w = 27'd100000000;
      default: w = 27'd0;
    endcase
    return w;
  endfunction

endpackage

@@ hdl/mwd_in_stage.sv @@
// ----------------------------------------------------------------------------
// Input stage
// Registers one incoming wheel transfer ahead of the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mwd_in_stage (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // [6:0] wheel_reading, [7] zero
  input  logic                         s_tlast,   // last_wheel
  input  logic                         advance,
  output logic                         held_valid,
  output logic [mwd_pkg::ReadingW-1:0] held_reading,
  output logic                         held_last
);

  // The register takes a new transfer when empty or when its item moves on.
  assign s_tready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (s_tready) begin
      held_valid <= s_tvalid;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      held_reading <= s_tdata[mwd_pkg::ReadingW-1:0];
      held_last    <= s_tlast;
    end
  end

endmodule

@@ hdl/mwd_wheel_decode.sv @@
// ----------------------------------------------------------------------------
// Wheel decoder
// Turns one raw wheel reading into a digit under the three carry modes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mwd_wheel_decode (
  input  logic [mwd_pkg::ReadingW-1:0] reading,
  input  mwd_pkg::lower_state_t        lower,
  output mwd_pkg::decode_t             result
);

  logic       forced;
  logic       carry;
  logic       prev_mid;
  logic       prev_high;
  logic [3:0] q2;
  logic [3:0] q5;
  logic [3:0] q7;
  logic [3:0] q0;
  logic [3:0] rem;

  assign forced    = (lower.mode == mwd_pkg::MODE_CARRY) ||
                     (lower.mode == mwd_pkg::MODE_FLOOR);
  assign carry     = (lower.mode == mwd_pkg::MODE_CARRY);
  assign prev_mid  = (lower.lower_reading >= mwd_pkg::MidLow) &&
                     (lower.lower_reading <= mwd_pkg::MidHigh);
  assign prev_high = (lower.lower_reading >= mwd_pkg::CarryLimit);

  // Rounded quotients used by the various rules.
  assign q0  = mwd_pkg::div10({1'b0, reading});
  assign q2  = mwd_pkg::div10({1'b0, reading} + 8'd2);
  assign q5  = mwd_pkg::div10({1'b0, reading} + 8'd5);
  assign q7  = mwd_pkg::div10({1'b0, reading} + 8'd7);
  assign rem = 4'(reading - 7'(q0 * 4'd10));

  // Digit, failure and next carry mode.
  always_comb begin
    result.digit     = mwd_pkg::mod10({1'b0, q5});
    result.fail      = 1'b0;
    result.next_mode = mwd_pkg::MODE_NORMAL;
    if (forced && prev_mid) begin
      // Lower wheel mid transition: round down, then add the forced carry.
      result.digit = mwd_pkg::mod10({1'b0, q2} + {4'd0, carry});
      if ((reading < mwd_pkg::MidLow) || (reading > mwd_pkg::StayHigh)) begin
        result.next_mode = mwd_pkg::MODE_NORMAL;
      end else begin
        result.next_mode = lower.mode;
      end
    end else if (forced && prev_high) begin
      // Lower wheel past the carry point: round up, and floor steps back one.
      result.digit = mwd_pkg::mod10({1'b0, q7} + (carry ? 5'd0 : 5'd9));
      if (reading < mwd_pkg::StayLow) begin
        result.next_mode = mwd_pkg::MODE_NORMAL;
      end else begin
        result.next_mode = lower.mode;
      end
    end else if (forced) begin
      // Forced mode without a high lower wheel decodes plainly.
      result.next_mode = mwd_pkg::MODE_NORMAL;
    end else begin
      if ((reading >= mwd_pkg::FloorLow) && (reading <= mwd_pkg::MidHigh)) begin
        result.next_mode = mwd_pkg::MODE_FLOOR;
      end else if (reading >= mwd_pkg::CarryLimit) begin
        result.next_mode = mwd_pkg::MODE_CARRY;
      end else begin
        result.next_mode = mwd_pkg::MODE_NORMAL;
        // A half-way reading cannot be settled once a lower wheel is known.
        result.fail      = (rem == 4'd5) && lower.lower_known;
      end
    end
  end

endmodule

@@ hdl/mwd_accum.sv @@
// ----------------------------------------------------------------------------
// Reading accumulator
// Holds the per-reading state, sums the running value and registers results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mwd_accum #(
  parameter int MAX_WHEELS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic                         held_valid,
  input  logic                         held_last,
  input  mwd_pkg::decode_t             dec,
  output mwd_pkg::lower_state_t        lower,
  input  logic [mwd_pkg::ReadingW-1:0] held_reading,
  output logic                         m_tvalid,
  output logic [31:0]                  m_tdata,   // [3:0] digit, [30:4] value, [31] zero
  output logic                         m_tuser,   // error
  output logic                         m_tlast    // is_last
);

  localparam int CountW = $clog2(MAX_WHEELS + 1);
  localparam logic [CountW-1:0] MaxCount = CountW'(MAX_WHEELS);

  logic                       fire;
  logic [CountW-1:0]          count;
  logic [mwd_pkg::ValueW-1:0] running;
  logic                       error_seen;
  logic [mwd_pkg::ValueW-1:0] weight;
  logic                       wheel_fail;
  logic                       error_next;
  logic [mwd_pkg::ValueW-1:0] running_next;

  assign fire   = held_valid && advance;
  assign weight = mwd_pkg::pow10(4'(count));

  // A wheel fails on too many wheels or on a decoding failure.
  assign wheel_fail   = (count >= MaxCount) || dec.fail;
  assign error_next   = error_seen || wheel_fail;
  assign running_next = running + mwd_pkg::ValueW'(dec.digit * weight);

  // Per-reading state, updated by each wheel and cleared after the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      lower.mode          <= mwd_pkg::MODE_NORMAL;
      lower.lower_reading <= '0;
      lower.lower_known   <= 1'b0;
      count               <= '0;
      running             <= '0;
      error_seen          <= 1'b0;
    end else if (fire) begin
      if (held_last) begin
        lower.mode          <= mwd_pkg::MODE_NORMAL;
        lower.lower_reading <= '0;
        lower.lower_known   <= 1'b0;
        count               <= '0;
        running             <= '0;
        error_seen          <= 1'b0;
      end else if (!error_next) begin
        lower.mode          <= dec.next_mode;
        lower.lower_reading <= held_reading;
        lower.lower_known   <= 1'b1;
        count               <= count + CountW'(1);
        running             <= running_next;
      end else begin
        error_seen <= 1'b1;
      end
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= held_valid;
    end
  end

  // Result payload; an error blanks digit and value.
  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata[31]  <= 1'b0;
      m_tdata[3:0] <= error_next ? '0 : dec.digit;
      m_tdata[30:4] <= error_next ? '0 : running_next;
      m_tuser      <= error_next;
      m_tlast      <= held_last;
    end
  end

endmodule

@@ hdl/meter_wheel_digit_decoder.sv @@
// Path: input stage register, then result register. Throughput: one wheel per
// cycle while the output does not stall; the carry mode, sum and weight loop
// closes through the decoder and a 4 by 27 bit multiply-add.
// Reset: synchronous, active high; clears both stage valid flags and the
// per-reading state (normal mode, no lower wheel, value zero, weight one).
// ----------------------------------------------------------------------------
// Meter wheel digit decoder
// Decodes counter-wheel readings, least significant first, into digits and a
// running decimal value with carry settling from the lower wheel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module meter_wheel_digit_decoder #(
  parameter int MAX_WHEELS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [6:0] wheel_reading, [7] zero
  input  logic        s_tlast,   // last_wheel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [3:0] digit, [30:4] value, [31] zero
  output logic        m_tuser,   // error
  output logic        m_tlast    // is_last
);

  logic                         advance;
  logic                         held_valid;
  logic [mwd_pkg::ReadingW-1:0] held_reading;
  logic                         held_last;
  mwd_pkg::lower_state_t        lower;
  mwd_pkg::decode_t             dec;

  // The held item moves on when the result register is free or being emptied.
  assign advance = !m_tvalid || m_tready;

  mwd_in_stage u_in (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tlast      (s_tlast),
    .advance      (advance),
    .held_valid   (held_valid),
    .held_reading (held_reading),
    .held_last    (held_last)
  );

  mwd_wheel_decode u_dec (
    .reading (held_reading),
    .lower   (lower),
    .result  (dec)
  );

  mwd_accum #(
    .MAX_WHEELS (MAX_WHEELS)
  ) u_acc (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .held_valid   (held_valid),
    .held_last    (held_last),
    .dec          (dec),
    .lower        (lower),
    .held_reading (held_reading),
    .m_tvalid     (m_tvalid),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .m_tlast      (m_tlast)
  );

endmodule

@@ tb/meter_wheel_digit_decoder_test.sv @@
// ----------------------------------------------------------------------------
// Meter wheel digit decoder testbench
// Sends whole meter readings, one wheel per transfer, with random gaps on the
// input and random back-pressure on the output. Each accepted wheel is run
// through a local model of the carry rules. Every result transfer is checked
// against the oldest outstanding prediction. A short table of hand-picked
// readings comes first, then random readings biased towards the carry
// thresholds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module meter_wheel_digit_decoder_test;

  localparam int MaxWheels   = 8;
  localparam int WeightLimit = 10 ** MaxWheels;
  localparam int RandomItems = 1450;
  localparam int MaxGap      = 13;
  localparam int HoldCycles  = 300;
  localparam int HoldAfter   = 300;
  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 16;
  localparam int ReportLimit = 10;
  localparam int DirectedRows = 24;

  // One decoded wheel as it leaves the block.
  typedef struct packed {
    logic [mwd_pkg::DigitW-1:0] digit;
    logic                       error;
    logic [mwd_pkg::ValueW-1:0] value;
    logic                       is_last;
  } wheel_result_t;

  // One row of the directed table; the result is only used when typed is set.
  typedef struct packed {
    logic [mwd_pkg::ReadingW-1:0] reading;
    logic                         last;
    logic                         typed;
    logic [mwd_pkg::DigitW-1:0]   digit;
    logic                         error;
    logic [mwd_pkg::ValueW-1:0]   value;
  } wheel_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [6:0] wheel_reading, [7] zero
  logic        s_tlast;   // last_wheel
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [3:0] digit, [30:4] value, [31] zero
  logic        m_tuser;   // error
  logic        m_tlast;   // is_last

  // Local copy of the per-reading decoder state.
  mwd_pkg::mode_t               pred_mode;
  logic [mwd_pkg::ReadingW-1:0] pred_lower;
  logic                         pred_lower_known;
  logic [mwd_pkg::ValueW-1:0]   pred_weight;
  logic [mwd_pkg::ValueW-1:0]   pred_sum;
  logic                         pred_error;

  wheel_result_t wheel_results[$];
  int            failures;
  int            results_seen;
  int            wheels_sent;
  int            idle_cycles;
  bit            hold_on;
  bit            hold_done;

  // Hand-picked readings: reset state, extremes, carry and floor settling,
  // a half-step reading above a known wheel, sticky errors and a ninth wheel.
  wheel_row_t directed_rows [0:DirectedRows-1] = '{
    '{7'd0,   1'b1, 1'b1, 4'd0, 1'b0, 27'd0},
    '{7'd99,  1'b1, 1'b1, 4'd0, 1'b0, 27'd0},
    '{7'd127, 1'b1, 1'b1, 4'd3, 1'b0, 27'd3},
    '{7'd7,   1'b0, 1'b0, 4'd0, 1'b0, 27'd0},
    '{7'd25,  1'b1, 1'b1, 4'd0, 1'b1, 27'd0},
    '{7'd92,  1'b0, 1'b0, 4'd0, 1'b0, 27'd0},
    '{7'd96,  1'b0, 1'b0, 4'd0, 1'b0, 27'd0},
    '{7'd5,   1'b1, 1'b0, 4'd0, 1'b0, 27'd0},
    '{7'd97,  1'b0, 1'b0, 4'd0, 1'b0, 27'd0},
    '{7'd94,  1'b0, 1'b0, 4'd0, 1'b0, 27'd0},
    '{7'd50,  1'b1, 1'b0, 4'd0, 1'b0, 27'd0},
    '{7'd5,   1'b0, 1'b0, 4'd0, 1'b0, 27'd0},
    '{7'd15,  1'b0, 1'b1, 4'd0, 1'b1, 27'd0},
    '{7'd3,   1'b0, 1'b1, 4'd0, 1'b1, 27'd0},
    '{7'd4,   1'b1, 1'b1, 4'd0, 1'b1, 27'd0},
    '{7'd90,  1'b0, 1'b0, 4'd0, 1'b0, 27'd0},
    '{7'd90,  1'b0, 1'b0, 4'd0, 1'b0, 27'd0},
    '{7'd90,  1'b0, 1'b0, 4'd0, 1'b0, 27'd0},
    '{7'd90,  1'b0, 1'b0, 4'd0, 1'b0, 27'd0},
    '{7'd90,  1'b0, 1'b0, 4'd0, 1'b0, 27'd0},
    '{7'd90,  1'b0, 1'b0, 4'd0, 1'b0, 27'd0},
    '{7'd90,  1'b0, 1'b0, 4'd0, 1'b0, 27'd0},
    '{7'd90,  1'b0, 1'b1, 4'd9, 1'b0, 27'd99999999},
    '{7'd0,   1'b1, 1'b1, 4'd0, 1'b1, 27'd0}
  };

  meter_wheel_digit_decoder #(
    .MAX_WHEELS(MaxWheels)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Returns the decoder state to its value at the start of a reading.
  function automatic void clear_reading();
    pred_mode        = mwd_pkg::MODE_NORMAL;
    pred_lower       = '0;
    pred_lower_known = 1'b0;
    pred_weight      = mwd_pkg::ValueW'(1);
    pred_sum         = '0;
    pred_error       = 1'b0;
  endfunction

  // Decodes one wheel against the local state and advances that state.
  function automatic wheel_result_t decode_wheel_reading(
      input logic [mwd_pkg::ReadingW-1:0] reading,
      input logic                         last);
    wheel_result_t res;
    int            r;
    int            q;
    int            d;
    bit            bad;
    bit            lower_mid;
    bit            lower_high;
    bit            forced;
    bit            carry;
    r          = reading;
    d          = 0;
    bad        = 1'b0;
    lower_mid  = (pred_lower >= mwd_pkg::MidLow) && (pred_lower <= mwd_pkg::MidHigh);
    lower_high = pred_lower >= mwd_pkg::CarryLimit;
    forced     = (pred_mode == mwd_pkg::MODE_CARRY) || (pred_mode == mwd_pkg::MODE_FLOOR);
    carry      = pred_mode == mwd_pkg::MODE_CARRY;
    if (!pred_error) begin
      if (pred_weight >= WeightLimit) begin
        pred_error = 1'b1;
      end else begin
        if (forced && lower_mid) begin
          // The wheel below sat mid-transition: round from two tenths.
          q = (r + 2) / 10 + (carry ? 1 : 0);
          if (r < mwd_pkg::MidLow || r > mwd_pkg::StayHigh) begin
            pred_mode = mwd_pkg::MODE_NORMAL;
          end
        end else if (forced && lower_high) begin
          q = (r + 7) / 10 + (carry ? 0 : 9);
          if (r < mwd_pkg::StayLow) begin
            pred_mode = mwd_pkg::MODE_NORMAL;
          end
        end else if (forced) begin
          pred_mode = mwd_pkg::MODE_NORMAL;
          q = (r + 5) / 10;
        end else begin
          // Normal mode; the unused mode code behaves the same way.
          if (r >= mwd_pkg::FloorLow && r <= mwd_pkg::MidHigh) begin
            pred_mode = mwd_pkg::MODE_FLOOR;
          end else if (r >= mwd_pkg::CarryLimit) begin
            pred_mode = mwd_pkg::MODE_CARRY;
          end else begin
            pred_mode = mwd_pkg::MODE_NORMAL;
            bad = (r % 10 == 5) && pred_lower_known;
          end
          q = (r + 5) / 10;
        end
        d = q % 10;
        if (bad) begin
          pred_error = 1'b1;
        end else begin
          pred_lower       = reading;
          pred_lower_known = 1'b1;
          pred_sum         = pred_sum + mwd_pkg::ValueW'(d) * pred_weight;
          pred_weight      = pred_weight * mwd_pkg::ValueW'(10);
        end
      end
    end
    res.digit   = pred_error ? '0 : mwd_pkg::DigitW'(d);
    res.error   = pred_error;
    res.value   = pred_error ? '0 : pred_sum;
    res.is_last = last;
    if (last) begin
      clear_reading();
    end
    return res;
  endfunction

  // Readings weighted towards the carry thresholds, with some half steps
  // and some values above the wheel range.
  function automatic logic [mwd_pkg::ReadingW-1:0] pick_reading();
    int k;
    int r;
    k = $urandom_range(0, 99);
    if (k < 45) begin
      r = $urandom_range(0, 99);
      if (r % 10 == 5) begin
        r = r + 1;
      end
    end else if (k < 75) begin
      r = $urandom_range(86, 99);
    end else if (k < 83) begin
      r = 10 * $urandom_range(0, 9) + 5;
    end else if (k < 93) begin
      r = $urandom_range(100, 127);
    end else begin
      r = $urandom_range(0, 127);
    end
    return mwd_pkg::ReadingW'(r);
  endfunction

  // Offers one wheel and waits for its transfer, then records the result.
  task automatic send_wheel(input logic [mwd_pkg::ReadingW-1:0] reading, input logic last,
                            input bit typed, input wheel_result_t typed_res);
    wheel_result_t predicted;
    int            gap;
    gap = (hold_on || (wheels_sent / 80) % 5 == 4) ? 0 : $urandom_range(0, MaxGap);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {1'b0, reading};
    s_tlast  <= last;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = decode_wheel_reading(reading, last);
    wheel_results.push_back(typed ? typed_res : predicted);
    wheels_sent++;
  endtask

  // Input side: reset, directed table, then random readings.
  initial begin
    wheel_row_t    row;
    wheel_result_t typed_res;
    int            len;
    int            k;
    rst          = 1'b1;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    s_tlast     <= 1'b0;
    failures     = 0;
    wheels_sent  = 0;
    clear_reading();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DirectedRows; i++) begin
      row       = directed_rows[i];
      typed_res = '{row.digit, row.error, row.value, row.last};
      send_wheel(row.reading, row.last, row.typed, typed_res);
    end

    // Mostly well-formed readings; some overrun the wheel count.
    while (wheels_sent < DirectedRows + RandomItems) begin
      k   = $urandom_range(0, 99);
      len = (k < 88) ? $urandom_range(1, MaxWheels) : $urandom_range(MaxWheels + 1, 11);
      for (int j = 0; j < len; j++) begin
        send_wheel(pick_reading(), j == len - 1, 1'b0, '0);
      end
    end
    s_tvalid <= 1'b0;

    while (wheel_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (failures == 0 && wheel_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Output side: random back-pressure, one long hold-off part-way through.
  initial begin
    int gap;
    m_tready <= 1'b0;
    hold_on   = 1'b0;
    hold_done = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && results_seen >= HoldAfter) begin
        m_tready <= 1'b0;
        hold_on   = 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_on   = 1'b0;
        hold_done = 1'b1;
      end
      gap = ((results_seen / 70) % 5 == 2) ? 0 : $urandom_range(0, MaxGap);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // Result check against the oldest outstanding prediction.
  always @(posedge clk) begin
    wheel_result_t got;
    wheel_result_t want;
    if (rst) begin
      results_seen <= 0;
    end else if (m_tvalid && m_tready) begin
      got = '{m_tdata[3:0], m_tuser, m_tdata[30:4], m_tlast};
      results_seen <= results_seen + 1;
      if (wheel_results.size() == 0) begin
        if (failures < ReportLimit) begin
          $display("unexpected result: digit %0d error %0b value %0d last %0b",
                   got.digit, got.error, got.value, got.is_last);
        end
        failures++;
      end else begin
        want = wheel_results.pop_front();
        if (got.digit !== want.digit || got.error !== want.error ||
            got.value !== want.value || got.is_last !== want.is_last) begin
          if (failures < ReportLimit) begin
            $display("result %0d mismatch: expected digit %0d error %0b value %0d last %0b,",
                     results_seen, want.digit, want.error, want.value, want.is_last);
            $display("  got digit %0d error %0b value %0d last %0b",
                     got.digit, got.error, got.value, got.is_last);
          end
          failures++;
        end
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

endmodule
